@@ sv/modbus_encapsulated_frame_builder_unit_macros.svh @@
// Assertion helpers for the frame builder. Each expects clk and rst in scope.
`ifndef MODBUS_ENCAPSULATED_FRAME_BUILDER_UNIT_MACROS_SVH
`define MODBUS_ENCAPSULATED_FRAME_BUILDER_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define MFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame builder check failed");

// Next-cycle implication, off during reset.
`define MFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame builder check failed");

`endif

@@ sv/mfb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mfb_pkg;

  localparam int MAX_DATA_BYTES = 4;
  localparam int SIZE_W = 3;
  localparam int BODY_BYTES = 17;                      // header through size field
  localparam int CRC_START = 4;                        // first byte under CRC
  localparam int LEN_BASE = 15;
  localparam int FRAME_MAX = BODY_BYTES + MAX_DATA_BYTES + 2;
  localparam int POS_W = $clog2(FRAME_MAX + 1);
  localparam int SREG_BYTES = BODY_BYTES + MAX_DATA_BYTES;

  localparam logic [7:0] HDR_0 = 8'h4E;
  localparam logic [7:0] HDR_1 = 8'h54;
  localparam logic [7:0] SVC_0 = 8'h2B;
  localparam logic [7:0] SVC_1 = 8'h0D;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd2;

  typedef struct packed {
    logic load;   // restart at CRC_INIT
    logic step;   // fold one byte in
  } crc_ctl_t;

endpackage

`default_nettype wire

@@ sv/mfb_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mfb_cmd_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] object_index;
  logic [7:0]  sub_index;
  logic [2:0]  data_bytes;
  logic [31:0] data_value;

  modport source (output valid, mode, object_index, sub_index, data_bytes, data_value,
                  input ready);
  modport sink (input valid, mode, object_index, sub_index, data_bytes, data_value,
                output ready);
endinterface

interface mfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

@@ sv/mfb_crc.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mfb_crc
  import mfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire crc_ctl_t    ctl,
  input  wire logic [7:0]  data_in,
  output logic      [15:0] crc
);

  logic [15:0] crc_next;

  // fold one byte, reflected, one bit per step
  always_comb begin
    crc_next = crc ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (crc_next[0]) begin
        crc_next = (crc_next >> 1) ^ CRC_POLY;
      end else begin
        crc_next = crc_next >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.load) begin
      crc <= CRC_INIT;
    end else if (ctl.step) begin
      crc <= crc_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/modbus_encapsulated_frame_builder_unit.sv @@
// Object-access frame builder: each accepted command word becomes one encapsulated frame
// of 19 + size bytes (size = data_bytes, capped at 4), sent on the byte channel in
// transmission order, with last_byte marking the CRC high byte. The command is taken into
// a byte-wide shift register; after that one byte leaves per cycle while the sink is
// ready, the bytes coming from the shift register and the byte-per-cycle CRC-16/Modbus
// unit. A new command is taken once the final byte has been loaded into the output
// register. The configuration registers (node address, channel id, start offset) are
// written through cfg_we, cfg_index and cfg_data; the user must write them only while
// no frame is in flight, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_encapsulated_frame_builder_unit_macros.svh"

module modbus_encapsulated_frame_builder_unit
  import mfb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  mfb_cmd_if.sink                   cmd,
  mfb_byte_if.source                tx
);

  typedef enum logic {IDLE, SEND} state_t;

  state_t                  state;
  logic [7:0]              node_address;
  logic [7:0]              channel_id;
  logic [15:0]             start_offset;

  // frame body, next byte to send in the top byte
  logic [SREG_BYTES*8-1:0] sreg;
  logic [SREG_BYTES*8-1:0] sreg_load;
  logic [MAX_DATA_BYTES*8-1:0] data_le;
  logic [SIZE_W-1:0]       size;
  logic [SIZE_W-1:0]       size_sat;
  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        body_end;
  logic [15:0]             crc;
  crc_ctl_t                crc_ctl;
  logic                    accept;
  logic                    emit;
  logic                    in_body;

  assign cmd.ready = (state == IDLE);
  assign accept    = cmd.valid && cmd.ready;

  // oversize requests saturate to the largest data field
  assign size_sat = (cmd.data_bytes > SIZE_W'(MAX_DATA_BYTES)) ?
                    SIZE_W'(MAX_DATA_BYTES) : cmd.data_bytes;

  // data goes out least significant byte first
  always_comb begin
    data_le = '0;
    for (int i = 0; i < MAX_DATA_BYTES; i++) begin
      data_le[(MAX_DATA_BYTES-1-i)*8 +: 8] = cmd.data_value[8*i +: 8];
    end
  end

  assign sreg_load = {HDR_0, HDR_1, 8'h00, 8'(LEN_BASE) + 8'(size_sat),
                      node_address, SVC_0, SVC_1, {7'b0, cmd.mode}, 8'h00,
                      channel_id, cmd.object_index[15:8], cmd.object_index[7:0],
                      cmd.sub_index, start_offset[15:8], start_offset[7:0],
                      8'h00, {{(8-SIZE_W){1'b0}}, size_sat}, data_le};

  // one frame byte per cycle whenever the output register is free or draining
  assign body_end = POS_W'(BODY_BYTES) + POS_W'(size);
  assign emit     = (state == SEND) && (!tx.valid || tx.ready);
  assign in_body  = (pos < body_end);

  assign crc_ctl.load = accept;
  assign crc_ctl.step = emit && in_body && (pos >= POS_W'(CRC_START));

  mfb_crc u_crc (
    .clk     (clk),
    .rst     (rst),
    .ctl     (crc_ctl),
    .data_in (sreg[SREG_BYTES*8-1 -: 8]),
    .crc     (crc)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= 8'd5;
      channel_id   <= 8'd1;
      start_offset <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_ADDRESS: node_address <= cfg_data[7:0];
        CFG_CHANNEL_ID:   channel_id   <= cfg_data[7:0];
        CFG_START_OFFSET: start_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      pos          <= '0;
      tx.valid     <= 1'b0;
      tx.last_byte <= 1'b0;
    end else begin
      if (tx.valid && tx.ready && !emit) begin
        tx.valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            state <= SEND;
            pos   <= '0;
          end
        end
        SEND: begin
          if (emit) begin
            tx.valid <= 1'b1;
            if (in_body) begin
              tx.last_byte <= 1'b0;
              pos          <= pos + POS_W'(1);
            end else if (pos == body_end) begin
              tx.last_byte <= 1'b0;
              pos          <= pos + POS_W'(1);
            end else begin
              // CRC high byte closes the frame
              tx.last_byte <= 1'b1;
              pos          <= '0;
              state        <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // payload: shift register and byte data need no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      sreg <= sreg_load;
      size <= size_sat;
    end else if (emit) begin
      if (in_body) begin
        tx.out_byte <= sreg[SREG_BYTES*8-1 -: 8];
        sreg        <= sreg << 8;
      end else if (pos == body_end) begin
        tx.out_byte <= crc[7:0];
      end else begin
        tx.out_byte <= crc[15:8];
      end
    end
  end

  // the closing byte is loaded only as the counter wraps; it never waits mid-frame
  `MFB_ASSERT_NOW(a_last_at_wrap, tx.valid && tx.last_byte, pos == '0)
  // every new frame restarts the CRC
  `MFB_ASSERT_NEXT(a_crc_reload, cmd.valid && cmd.ready, crc == CRC_INIT)
  // byte counter never runs past the longest frame
  `MFB_ASSERT_NOW(a_pos_range, state == SEND, pos < POS_W'(FRAME_MAX))

endmodule

`default_nettype wire
